[sv/wsdf_pkg.sv]
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared constants and types for the WebSocket frame deframer and unmasker.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // Width of the payload byte counter; longer declared lengths are errors.
    localparam int unsigned LEN_BITS = 32;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN  = 64'd125;

    localparam logic [2:0] ERR_RESERVED   = 3'd0;
    localparam logic [2:0] ERR_BAD_OPCODE = 3'd1;
    localparam logic [2:0] ERR_LEN_MSB    = 3'd2;
    localparam logic [2:0] ERR_FRAG_CTRL  = 3'd3;
    localparam logic [2:0] ERR_BIG_CTRL   = 3'd4;
    localparam logic [2:0] ERR_UNMASKED   = 3'd5;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd6;
    localparam logic [2:0] ERR_TRUNC_CLOSE = 3'd7;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic [3:0]  frame_opcode;
        logic        final_fragment;
        logic [31:0] payload_length;
        logic        close_present;
        logic [15:0] close_status;
        logic        protocol_error;
        logic [2:0]  error_kind;
    } res_t;

endpackage

[sv/wsdf_parser.sv]
// ----------------------------------------------------------------------------
// wsdf_parser
// Frame parser state and the per-byte update: header, extended length, mask
// key, payload unmasking, close status capture and sticky error detection.
// ----------------------------------------------------------------------------
module wsdf_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic [31:0]        max_payload,
    output logic               has_result,
    output wsdf_pkg::res_t     result
);

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    phase_t                          phase_reg,  phase_next;
    logic [3:0]                      cnt_reg,    cnt_next;
    logic [3:0]                      opcode_reg, opcode_next;
    logic                            fin_reg,    fin_next;
    logic [63:0]                     len_reg,    len_next;
    logic [wsdf_pkg::LEN_BITS-1:0]   idx_reg,    idx_next;
    logic [31:0]                     mask_reg,   mask_next;
    logic [15:0]                     close_reg,  close_next;
    logic                            err_reg,    err_next;
    logic [2:0]                      kind_reg,   kind_next;

    logic                            done;
    logic                            pvalid;
    logic [7:0]                      pbyte;
    logic [7:0]                      mask_byte;
    logic [7:0]                      plain;
    logic [63:0]                     shifted;
    logic [wsdf_pkg::LEN_BITS:0]     idx_inc;
    logic                            is_close;

    function automatic logic opcode_known(input logic [3:0] op);
        begin
            opcode_known = (op == wsdf_pkg::OP_CONT) || (op == wsdf_pkg::OP_TEXT)
                || (op == wsdf_pkg::OP_BIN) || (op == wsdf_pkg::OP_CLOSE)
                || (op == wsdf_pkg::OP_PING) || (op == wsdf_pkg::OP_PONG);
        end
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        close_next  = close_reg;
        err_next    = err_reg;
        kind_next   = kind_reg;
        has_result  = 1'b0;
        done        = 1'b0;
        pvalid      = 1'b0;
        pbyte       = 8'd0;
        shifted     = {len_reg[55:0], data_byte};
        idx_inc     = {1'b0, idx_reg} + {{wsdf_pkg::LEN_BITS{1'b0}}, 1'b1};

        case (idx_reg[1:0])
            2'd0:    mask_byte = mask_reg[31:24];
            2'd1:    mask_byte = mask_reg[23:16];
            2'd2:    mask_byte = mask_reg[15:8];
            default: mask_byte = mask_reg[7:0];
        endcase
        plain = data_byte ^ mask_byte;

        if (err_reg)
        begin
            has_result = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = data_byte[3:0];
                    fin_next    = data_byte[7];
                    len_next    = 64'd0;
                    idx_next    = '0;
                    mask_next   = 32'd0;
                    close_next  = 16'd0;
                    cnt_next    = 4'd0;
                    if (data_byte[6:4] != 3'd0)
                    begin
                        err_next  = 1'b1;
                        kind_next = wsdf_pkg::ERR_RESERVED;
                    end
                    else if (!opcode_known(data_byte[3:0]))
                    begin
                        err_next  = 1'b1;
                        kind_next = wsdf_pkg::ERR_BAD_OPCODE;
                    end
                    else if (data_byte[3] && !data_byte[7])
                    begin
                        err_next  = 1'b1;
                        kind_next = wsdf_pkg::ERR_FRAG_CTRL;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1, PH_EXT16, PH_EXT64:
                begin
                    if (phase_reg == PH_HDR1)
                    begin
                        shifted = {57'd0, data_byte[6:0]};
                    end
                    len_next = shifted;
                    if (phase_reg != PH_HDR1)
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                    if (phase_reg == PH_HDR1 && !data_byte[7])
                    begin
                        err_next  = 1'b1;
                        kind_next = wsdf_pkg::ERR_UNMASKED;
                    end
                    else if (phase_reg == PH_HDR1
                        && data_byte[6:0] == wsdf_pkg::LEN_CODE_EXT16)
                    begin
                        len_next   = 64'd0;
                        cnt_next   = 4'd0;
                        phase_next = PH_EXT16;
                    end
                    else if (phase_reg == PH_HDR1
                        && data_byte[6:0] == wsdf_pkg::LEN_CODE_EXT64)
                    begin
                        len_next   = 64'd0;
                        cnt_next   = 4'd0;
                        phase_next = PH_EXT64;
                    end
                    else if (phase_reg == PH_HDR1
                        || (phase_reg == PH_EXT16 && cnt_next >= 4'd2)
                        || (phase_reg == PH_EXT64 && cnt_next >= 4'd8))
                    begin
                        if (shifted[63])
                        begin
                            err_next  = 1'b1;
                            kind_next = wsdf_pkg::ERR_LEN_MSB;
                        end
                        else if (opcode_reg[3] && shifted > wsdf_pkg::CTRL_MAX_LEN)
                        begin
                            err_next  = 1'b1;
                            kind_next = wsdf_pkg::ERR_BIG_CTRL;
                        end
                        else if (shifted > {32'd0, max_payload}
                            || (|shifted[63:wsdf_pkg::LEN_BITS]))
                        begin
                            err_next  = 1'b1;
                            kind_next = wsdf_pkg::ERR_TOO_LARGE;
                        end
                        else if (opcode_reg == wsdf_pkg::OP_CLOSE && shifted == 64'd1)
                        begin
                            err_next  = 1'b1;
                            kind_next = wsdf_pkg::ERR_TRUNC_CLOSE;
                        end
                        else
                        begin
                            phase_next = PH_MASK;
                            cnt_next   = 4'd0;
                        end
                    end
                end
                PH_MASK:
                begin
                    mask_next = {mask_reg[23:0], data_byte};
                    cnt_next  = cnt_reg + 4'd1;
                    if (cnt_next >= 4'd4)
                    begin
                        cnt_next = 4'd0;
                        idx_next = '0;
                        if (len_reg == 64'd0)
                        begin
                            phase_next = PH_HDR0;
                            has_result = 1'b1;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    done     = idx_inc >= len_reg[wsdf_pkg::LEN_BITS:0];
                    idx_next = idx_inc[wsdf_pkg::LEN_BITS-1:0];
                    if (done)
                    begin
                        phase_next = PH_HDR0;
                    end
                    if (opcode_reg == wsdf_pkg::OP_CLOSE
                        && idx_reg[wsdf_pkg::LEN_BITS-1:1] == '0)
                    begin
                        if (!idx_reg[0])
                        begin
                            close_next = {plain, 8'd0};
                        end
                        else
                        begin
                            close_next = {close_reg[15:8], plain};
                        end
                        has_result = done;
                    end
                    else
                    begin
                        has_result = 1'b1;
                        pvalid     = 1'b1;
                        pbyte      = plain;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
            if (err_next)
            begin
                has_result = 1'b1;
            end
        end
    end

    always_comb
    begin
        is_close = done && opcode_next == wsdf_pkg::OP_CLOSE && len_next >= 64'd2;
        result.payload_valid  = pvalid;
        result.payload_byte   = pbyte;
        result.frame_done     = done;
        result.frame_opcode   = opcode_next;
        result.final_fragment = fin_next;
        result.payload_length = len_next[31:0];
        result.close_present  = is_close;
        result.close_status   = is_close ? close_next : 16'd0;
        result.protocol_error = err_next;
        result.error_kind     = err_next ? kind_next : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            cnt_reg    <= 4'd0;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
            len_reg    <= 64'd0;
            idx_reg    <= '0;
            mask_reg   <= 32'd0;
            close_reg  <= 16'd0;
            err_reg    <= 1'b0;
            kind_reg   <= 3'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            mask_reg   <= mask_next;
            close_reg  <= close_next;
            err_reg    <= err_next;
            kind_reg   <= kind_next;
        end
    end

`ifndef SYNTH
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg && $stable(kind_reg))
        else $error("error state left without reset");

    a_err_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> $stable(phase_reg) && $stable(len_reg) && $stable(idx_reg))
        else $error("parser state moved in error state");

    a_payload_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        step && has_result && result.payload_valid |-> phase_reg == PH_DATA && !err_reg)
        else $error("payload byte outside data phase");

    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_done |=> phase_reg == PH_HDR0)
        else $error("frame done without return to header");
`endif

endmodule

[sv/ws_frame_deframer_unmask_core.sv]
// ----------------------------------------------------------------------------
// ws_frame_deframer_unmask_core
// out_valid is registered: the parser result for the byte in the input register is
// captured in the result register. Throughput: one byte per cycle unless out_ready
// stalls; one input and one result register, with the parser update between them.
// Reset: rst_n clears all control state and sets max_payload to 65536.
// ----------------------------------------------------------------------------
module ws_frame_deframer_unmask_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic        frame_done,
    output logic [3:0]  frame_opcode,
    output logic        final_fragment,
    output logic [31:0] payload_length,
    output logic        close_present,
    output logic [15:0] close_status,
    output logic        protocol_error,
    output logic [2:0]  error_kind,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               out_valid_reg;
    wsdf_pkg::res_t     out_reg;
    logic [31:0]        max_payload_reg;
    logic               advance;
    logic               step;
    logic               res_has;
    wsdf_pkg::res_t     res;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    wsdf_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (s1_byte_reg),
        .max_payload (max_payload_reg),
        .has_result  (res_has),
        .result      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            max_payload_reg <= wsdf_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= step && res_has;
            end
            if (cfg_wr_en)
            begin
                max_payload_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
        if (step && res_has)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_valid  = out_reg.payload_valid;
    assign payload_byte   = out_reg.payload_byte;
    assign frame_done     = out_reg.frame_done;
    assign frame_opcode   = out_reg.frame_opcode;
    assign final_fragment = out_reg.final_fragment;
    assign payload_length = out_reg.payload_length;
    assign close_present  = out_reg.close_present;
    assign close_status   = out_reg.close_status;
    assign protocol_error = out_reg.protocol_error;
    assign error_kind     = out_reg.error_kind;

endmodule
